// ===== src/ccpp_pkg.sv =====
// ----------------------------------------------------------------------------
// ccpp_pkg
// Shared types and constants for the capacity checked partition placer.
// ----------------------------------------------------------------------------
package ccpp_pkg;

  localparam int DEF_MAX_PARTITIONS = 16;
  localparam int DEF_COUNT_WIDTH    = 16;

  localparam int DEG_W   = 16;
  localparam int LIMIT_W = 16;
  localparam int NPART_W = 5;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_PART_COUNT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NODE_LIMIT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INEDGE_LIMIT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUTEDGE_LIMIT  = 2'd3;

  localparam logic [1:0] ST_PLACED    = 2'd0;
  localparam logic [1:0] ST_NO_FIT    = 2'd1;
  localparam logic [1:0] ST_BAD_START = 2'd2;

  typedef struct packed {
    logic        clear_first;
    logic [3:0]  start_partition;
    logic [15:0] in_degree;
    logic [15:0] out_degree;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  chosen_partition;
    logic [15:0] local_slot;
    logic [15:0] inedge_base;
    logic [15:0] outedge_base;
  } out_word_t;

  typedef struct packed {
    logic [DEG_W-1:0] in_degree;
    logic [DEG_W-1:0] out_degree;
  } deg_t;

  typedef struct packed {
    logic load;
    logic kill;
    logic clear;
  } cell_ctl_t;

endpackage

// ===== src/ccpp_cell.sv =====
// ----------------------------------------------------------------------------
// ccpp_cell
// One partition: node count and edge totals, plus the search token.
// ----------------------------------------------------------------------------
module ccpp_cell #(
  parameter int COUNT_WIDTH = ccpp_pkg::DEF_COUNT_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ccpp_pkg::cell_ctl_t    ctl,
  input  logic                   sel,
  input  logic                   tok_in,
  input  ccpp_pkg::deg_t         deg,
  input  logic [COUNT_WIDTH-1:0] nlim,
  input  logic [COUNT_WIDTH-1:0] ilim,
  input  logic [COUNT_WIDTH-1:0] olim,
  output logic                   tok,
  output logic                   fit,
  output logic                   tok_out,
  output logic [COUNT_WIDTH-1:0] node_cnt,
  output logic [COUNT_WIDTH-1:0] in_cnt,
  output logic [COUNT_WIDTH-1:0] out_cnt
);

  localparam int SW = ((COUNT_WIDTH > ccpp_pkg::DEG_W) ? COUNT_WIDTH : ccpp_pkg::DEG_W) + 1;

  logic                   tok_r, tok_nxt;
  logic [COUNT_WIDTH-1:0] node_r, node_nxt;
  logic [COUNT_WIDTH-1:0] in_r, in_nxt;
  logic [COUNT_WIDTH-1:0] out_r, out_nxt;
  logic [SW-1:0]          in_sum, out_sum;

  assign in_sum  = SW'(in_r) + SW'(deg.in_degree);
  assign out_sum = SW'(out_r) + SW'(deg.out_degree);

  assign fit = tok_r && (node_r < nlim) && (in_sum <= SW'(ilim)) && (out_sum <= SW'(olim));
  assign tok_out = tok_r && !fit;

  always_comb begin
    priority if (ctl.load) begin
      tok_nxt = sel;
    end else if (ctl.kill) begin
      tok_nxt = 1'b0;
    end else begin
      tok_nxt = tok_in;
    end
  end

  always_comb begin
    node_nxt = node_r;
    in_nxt   = in_r;
    out_nxt  = out_r;
    priority if (ctl.clear) begin
      node_nxt = '0;
      in_nxt   = '0;
      out_nxt  = '0;
    end else if (fit) begin
      node_nxt = node_r + COUNT_WIDTH'(1);
      in_nxt   = COUNT_WIDTH'(in_sum);
      out_nxt  = COUNT_WIDTH'(out_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r  <= 1'b0;
      node_r <= '0;
      in_r   <= '0;
      out_r  <= '0;
    end else begin
      tok_r  <= tok_nxt;
      node_r <= node_nxt;
      in_r   <= in_nxt;
      out_r  <= out_nxt;
    end
  end

  assign tok      = tok_r;
  assign node_cnt = node_r;
  assign in_cnt   = in_r;
  assign out_cnt  = out_r;

endmodule

// ===== src/capacity_checked_partition_placer_unit.sv =====
// ----------------------------------------------------------------------------
// capacity_checked_partition_placer_unit
// Round-robin first-fit placement of graph nodes into capacity-limited
// partitions, built as a ring of partition cells that pass a search token.
// ----------------------------------------------------------------------------
// A node word is taken when start is high and busy is low. A start partition
// outside the active partition count is answered on the next cycle without
// busy rising. Otherwise a token visits one partition cell per cycle, from
// the start partition round the ring, and busy stays high until the fitting
// or last active partition has been tried. The result word is strobed on
// out_valid in the cycle after the fitting or last partition was tried. A
// new node may be started in the cycle that the previous result is shown.
// The result is held for one cycle only, as the receiver cannot stall.
module capacity_checked_partition_placer_unit #(
  parameter int MAX_PARTITIONS = ccpp_pkg::DEF_MAX_PARTITIONS,
  parameter int COUNT_WIDTH    = ccpp_pkg::DEF_COUNT_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  ccpp_pkg::in_word_t               in_data,
  output logic                             out_valid,
  output ccpp_pkg::out_word_t              out_data,
  input  logic                             cfg_we,
  input  logic [ccpp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ccpp_pkg::CFG_W-1:0]       cfg_data
);

  localparam int NW   = $clog2(MAX_PARTITIONS + 1);
  localparam int IW   = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
  localparam int CMPW = (NW > ccpp_pkg::NPART_W) ? NW : ccpp_pkg::NPART_W;
  localparam int LW   = (COUNT_WIDTH > ccpp_pkg::LIMIT_W) ? COUNT_WIDTH : ccpp_pkg::LIMIT_W;
  localparam int SX   = (CMPW > 4) ? CMPW : 4;

  localparam logic S_IDLE   = 1'b0;
  localparam logic S_SEARCH = 1'b1;

  logic                          state_r, state_nxt;
  logic [NW-1:0]                 k_r, k_nxt;
  logic                          out_valid_r, out_valid_nxt;
  ccpp_pkg::out_word_t           out_data_r, out_data_nxt;
  ccpp_pkg::deg_t                deg_r, deg_nxt;

  logic [ccpp_pkg::NPART_W-1:0]  part_count_r;
  logic [ccpp_pkg::LIMIT_W-1:0]  node_limit_r;
  logic [ccpp_pkg::LIMIT_W-1:0]  inedge_limit_r;
  logic [ccpp_pkg::LIMIT_W-1:0]  outedge_limit_r;

  logic [NW-1:0]                 n_eff;
  logic [COUNT_WIDTH-1:0]        nlim, ilim, olim;
  logic                          accept, bad_start, found, exhausted;
  ccpp_pkg::cell_ctl_t           ctl;

  logic [MAX_PARTITIONS-1:0]     tok, fit, tok_out, tok_in, sel;
  logic [COUNT_WIDTH-1:0]        node_cnt [MAX_PARTITIONS];
  logic [COUNT_WIDTH-1:0]        in_cnt   [MAX_PARTITIONS];
  logic [COUNT_WIDTH-1:0]        out_cnt  [MAX_PARTITIONS];
  logic [IW-1:0]                 part_idx;
  logic [COUNT_WIDTH-1:0]        sel_node, sel_in, sel_out;
  logic                          wrap_tok;

  always_comb begin
    if (part_count_r == '0) begin
      n_eff = NW'(1);
    end else if (CMPW'(part_count_r) > CMPW'(MAX_PARTITIONS)) begin
      n_eff = NW'(MAX_PARTITIONS);
    end else begin
      n_eff = NW'(part_count_r);
    end
  end

  assign nlim = (LW'(node_limit_r) > LW'({COUNT_WIDTH{1'b1}})) ?
                {COUNT_WIDTH{1'b1}} : COUNT_WIDTH'(node_limit_r);
  assign ilim = (LW'(inedge_limit_r) > LW'({COUNT_WIDTH{1'b1}})) ?
                {COUNT_WIDTH{1'b1}} : COUNT_WIDTH'(inedge_limit_r);
  assign olim = (LW'(outedge_limit_r) > LW'({COUNT_WIDTH{1'b1}})) ?
                {COUNT_WIDTH{1'b1}} : COUNT_WIDTH'(outedge_limit_r);

  assign busy      = (state_r == S_SEARCH);
  assign accept    = start && !busy;
  assign bad_start = SX'(in_data.start_partition) >= SX'(n_eff);
  assign found     = busy && (|fit);
  assign exhausted = busy && !(|fit) && (k_r == n_eff - NW'(1));

  assign ctl.load  = accept;
  assign ctl.kill  = exhausted;
  assign ctl.clear = accept && in_data.clear_first;

  always_comb begin
    wrap_tok = 1'b0;
    for (int i = 0; i < MAX_PARTITIONS; i++) begin
      sel[i] = !bad_start && (SX'(in_data.start_partition) == SX'(i));
      if (NW'(i) == n_eff - NW'(1)) begin
        wrap_tok = wrap_tok | tok_out[i];
      end
    end
  end

  genvar g;
  generate
    for (g = 0; g < MAX_PARTITIONS; g++) begin : g_cell
      if (g == 0) begin : g_first
        assign tok_in[g] = wrap_tok;
      end else begin : g_rest
        assign tok_in[g] = tok_out[g-1] && (NW'(g) < n_eff);
      end

      ccpp_cell #(
        .COUNT_WIDTH(COUNT_WIDTH)
      ) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .sel      (sel[g]),
        .tok_in   (tok_in[g]),
        .deg      (deg_r),
        .nlim     (nlim),
        .ilim     (ilim),
        .olim     (olim),
        .tok      (tok[g]),
        .fit      (fit[g]),
        .tok_out  (tok_out[g]),
        .node_cnt (node_cnt[g]),
        .in_cnt   (in_cnt[g]),
        .out_cnt  (out_cnt[g])
      );
    end
  endgenerate

  always_comb begin
    part_idx = '0;
    sel_node = '0;
    sel_in   = '0;
    sel_out  = '0;
    for (int i = 0; i < MAX_PARTITIONS; i++) begin
      if (fit[i]) begin
        part_idx = part_idx | IW'(i);
        sel_node = sel_node | node_cnt[i];
        sel_in   = sel_in | in_cnt[i];
        sel_out  = sel_out | out_cnt[i];
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    deg_nxt       = deg_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          deg_nxt.in_degree  = in_data.in_degree;
          deg_nxt.out_degree = in_data.out_degree;
          k_nxt              = '0;
          if (bad_start) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{status: ccpp_pkg::ST_BAD_START, default: '0};
          end else begin
            state_nxt = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        k_nxt = k_r + NW'(1);
        if (found) begin
          state_nxt                     = S_IDLE;
          out_valid_nxt                 = 1'b1;
          out_data_nxt.status           = ccpp_pkg::ST_PLACED;
          out_data_nxt.chosen_partition = 4'(part_idx);
          out_data_nxt.local_slot       = 16'(sel_node);
          out_data_nxt.inedge_base      = 16'(sel_in);
          out_data_nxt.outedge_base     = 16'(sel_out);
        end else if (exhausted) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{status: ccpp_pkg::ST_NO_FIT, default: '0};
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      k_r              <= '0;
      out_valid_r      <= 1'b0;
      part_count_r     <= 5'd16;
      node_limit_r     <= 16'hFFFF;
      inedge_limit_r   <= 16'hFFFF;
      outedge_limit_r  <= 16'hFFFF;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          ccpp_pkg::REG_PART_COUNT:     part_count_r     <= cfg_data[ccpp_pkg::NPART_W-1:0];
          ccpp_pkg::REG_NODE_LIMIT:     node_limit_r     <= cfg_data;
          ccpp_pkg::REG_INEDGE_LIMIT:   inedge_limit_r   <= cfg_data;
          ccpp_pkg::REG_OUTEDGE_LIMIT:  outedge_limit_r  <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    deg_r      <= deg_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The search token exists only while a search runs, and at one cell.
  a_token_onehot : assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok))
    else $error("More than one partition cell holds the search token.");

  a_token_in_search : assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> $onehot(tok))
    else $error("Search running without a token.");

  a_token_idle : assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> (tok == '0))
    else $error("Token left behind after the search ended.");

  a_bad_start : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && bad_start) |=> (out_valid && out_data.status == ccpp_pkg::ST_BAD_START))
    else $error("Bad start partition not reported on the next cycle.");

  a_unplaced_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != ccpp_pkg::ST_PLACED) |->
      (out_data.chosen_partition == '0 && out_data.local_slot == '0))
    else $error("Unplaced word carries placement fields.");

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the capacity checked partition placer unit.
// Node words are driven through the start/busy handshake. A directed table
// runs first, followed by randomised phases, each under its own register
// setting. A predictor that mirrors the per-partition node and edge counts
// works out each placement word, unless a directed step gives its own
// expected word, and each strobed result is checked against it in order.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ccpp_pkg::*;

  localparam int MAXP      = DEF_MAX_PARTITIONS;
  localparam int COUNT_MAX = (1 << DEF_COUNT_WIDTH) - 1;
  localparam int RANDOM_NODES = 1450;

  typedef struct {
    bit                   is_reg;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     val;
    in_word_t             node;
    bit                   typed;
    out_word_t            res;
  } step_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  in_word_t             in_data = '0;
  logic                 out_valid;
  out_word_t            out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  int unsigned slot_count [MAXP];
  int unsigned inedge_sum [MAXP];
  int unsigned outedge_sum[MAXP];
  logic [NPART_W-1:0] parts_reg = 5'd16;
  int unsigned node_lim_reg  = 65535;
  int unsigned in_lim_reg    = 65535;
  int unsigned out_lim_reg   = 65535;

  out_word_t placements_due[$];
  step_t     directed[$];
  bit        typed_pending = 1'b0;
  out_word_t typed_word = '0;

  int errors = 0;
  int n_placed = 0;
  int n_nofit = 0;
  int n_bad = 0;
  int n_nodes = 0;
  int n_settings = 0;

  capacity_checked_partition_placer_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int active_parts();
    int n;
    n = parts_reg;
    if (n == 0) n = 1;
    if (n > MAXP) n = MAXP;
    return n;
  endfunction

  function automatic int unsigned capped(int unsigned lim);
    return (lim < COUNT_MAX) ? lim : COUNT_MAX;
  endfunction

  function automatic out_word_t place_node(in_word_t w);
    out_word_t r;
    int n;
    int p;
    bit found;
    r = '0;
    found = 1'b0;
    if (w.clear_first) begin
      for (int i = 0; i < MAXP; i++) begin
        slot_count[i] = 0;
        inedge_sum[i] = 0;
        outedge_sum[i] = 0;
      end
    end
    n = active_parts();
    if (w.start_partition >= n) begin
      r.status = ST_BAD_START;
      return r;
    end
    r.status = ST_NO_FIT;
    for (int k = 0; k < n; k++) begin
      p = (int'(w.start_partition) + k) % n;
      if (!found && slot_count[p] < capped(node_lim_reg) &&
          inedge_sum[p] + w.in_degree <= capped(in_lim_reg) &&
          outedge_sum[p] + w.out_degree <= capped(out_lim_reg)) begin
        found = 1'b1;
        r.status = ST_PLACED;
        r.chosen_partition = 4'(p);
        r.local_slot = 16'(slot_count[p]);
        r.inedge_base = 16'(inedge_sum[p]);
        r.outedge_base = 16'(outedge_sum[p]);
        slot_count[p] += 1;
        inedge_sum[p] += w.in_degree;
        outedge_sum[p] += w.out_degree;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    out_word_t want;
    out_word_t pred;
    if (rst_n && cfg_we) begin
      case (cfg_index)
        REG_PART_COUNT:     parts_reg = cfg_data[NPART_W-1:0];
        REG_NODE_LIMIT:     node_lim_reg = cfg_data;
        REG_INEDGE_LIMIT:   in_lim_reg = cfg_data;
        REG_OUTEDGE_LIMIT:  out_lim_reg = cfg_data;
        default: ;
      endcase
    end
    if (rst_n && out_valid) begin
      case (out_data.status)
        ST_PLACED: n_placed++;
        ST_NO_FIT: n_nofit++;
        default:   n_bad++;
      endcase
      if (placements_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("Unexpected result word: st=%0d p=%0d slot=%0d ib=%0d ob=%0d",
                   out_data.status, out_data.chosen_partition, out_data.local_slot,
                   out_data.inedge_base, out_data.outedge_base);
      end else begin
        want = placements_due.pop_front();
        if (out_data.status !== want.status ||
            out_data.chosen_partition !== want.chosen_partition ||
            out_data.local_slot !== want.local_slot ||
            out_data.inedge_base !== want.inedge_base ||
            out_data.outedge_base !== want.outedge_base) begin
          errors++;
          if (errors <= 10)
            $display({"Mismatch: expected st=%0d p=%0d slot=%0d ib=%0d ob=%0d, ",
                      "got st=%0d p=%0d slot=%0d ib=%0d ob=%0d"},
                     want.status, want.chosen_partition, want.local_slot,
                     want.inedge_base, want.outedge_base,
                     out_data.status, out_data.chosen_partition, out_data.local_slot,
                     out_data.inedge_base, out_data.outedge_base);
        end
      end
    end
    if (rst_n && start && !busy) begin
      pred = place_node(in_data);
      placements_due.push_back(typed_pending ? typed_word : pred);
      n_nodes++;
    end
  end

  task automatic add_node(bit clr, int st, int indeg, int outdeg, bit typed,
                          out_word_t res);
    step_t s;
    s = '{is_reg: 1'b0, idx: '0, val: '0, node: '0, typed: typed, res: res};
    s.node = '{clear_first: clr, start_partition: 4'(st),
               in_degree: 16'(indeg), out_degree: 16'(outdeg)};
    directed.push_back(s);
  endtask

  task automatic add_reg(logic [CFG_IDX_W-1:0] idx, int val);
    step_t s;
    s = '{is_reg: 1'b1, idx: idx, val: 16'(val), node: '0, typed: 1'b0, res: '0};
    directed.push_back(s);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_node(in_word_t w, bit may_idle);
    int gap;
    gap = (may_idle && $urandom_range(0, 99) < 20) ? $urandom_range(1, 6) : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data <= w;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic settle();
    start <= 1'b0;
    while (placements_due.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  function automatic logic [15:0] pick_degree(int unsigned lim);
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 16'($urandom_range(0, lim / 6));
    if (r < 80) return 16'($urandom());
    if (r < 90) return 16'd0;
    return 16'hFFFF;
  endfunction

  function automatic logic [15:0] pick_edge_limit();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 16'd0;
    if (r < 40) return 16'($urandom_range(1, 2000));
    if (r < 70) return 16'hFFFF;
    return 16'($urandom());
  endfunction

  initial begin
    out_word_t placed0;
    out_word_t no_fit;
    out_word_t bad;
    in_word_t  w;
    logic [CFG_W-1:0] v;
    int sent;
    int len;
    int r;

    placed0 = '{status: ST_PLACED, default: '0};
    no_fit  = '{status: ST_NO_FIT, default: '0};
    bad     = '{status: ST_BAD_START, default: '0};

    add_node(0, 0, 0, 0, 1, placed0);
    add_node(0, 15, 16'hFFFF, 16'hFFFF, 1,
             '{status: ST_PLACED, chosen_partition: 4'd15, default: '0});
    add_node(0, 15, 1, 0, 0, '0);
    add_node(0, 7, 16'h8000, 16'h0001, 0, '0);
    add_reg(REG_PART_COUNT, 4);
    add_node(0, 4, 16'h1234, 16'h4321, 1, bad);
    add_node(1, 3, 5, 7, 1, '{status: ST_PLACED, chosen_partition: 4'd3, default: '0});
    add_reg(REG_NODE_LIMIT, 0);
    add_node(0, 0, 0, 0, 1, no_fit);
    add_node(1, 1, 3, 3, 1, no_fit);
    add_reg(REG_NODE_LIMIT, 1);
    repeat (4) add_node(0, 2, 1, 1, 0, '0);
    add_node(0, 2, 0, 0, 0, '0);
    add_reg(REG_PART_COUNT, 0);
    add_node(0, 1, 0, 0, 1, bad);
    add_node(1, 0, 16'hFFFF, 16'hFFFF, 1, placed0);
    add_reg(REG_PART_COUNT, 16'hFFFF);
    add_reg(REG_NODE_LIMIT, 16'hFFFF);
    add_reg(REG_INEDGE_LIMIT, 0);
    add_node(0, 15, 0, 16'hFFFF, 0, '0);
    add_node(0, 9, 1, 0, 1, no_fit);
    add_reg(REG_INEDGE_LIMIT, 16'hFFFF);
    add_reg(REG_OUTEDGE_LIMIT, 0);
    add_node(0, 5, 0, 1, 1, no_fit);
    add_node(0, 5, 16'hAAAA, 0, 0, '0);
    add_reg(REG_OUTEDGE_LIMIT, 16'hFFFF);

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed[i]) begin
      if (directed[i].is_reg) begin
        settle();
        write_reg(directed[i].idx, directed[i].val);
        n_settings++;
      end else begin
        typed_pending = directed[i].typed;
        typed_word = directed[i].res;
        send_node(directed[i].node, 1'b1);
      end
    end
    typed_pending = 1'b0;

    sent = 0;
    while (sent < RANDOM_NODES) begin
      settle();
      r = $urandom_range(0, 99);
      if (r < 10) v = 16'd0;
      else if (r < 20) v = 16'($urandom_range(17, 31));
      else if (r < 35) v = 16'd16;
      else if (r < 50) v = 16'd1;
      else v = 16'($urandom_range(2, 15));
      if ($urandom_range(0, 3) == 0) v[15:NPART_W] = 11'($urandom());
      write_reg(REG_PART_COUNT, v);
      r = $urandom_range(0, 99);
      if (r < 5) v = 16'd0;
      else if (r < 45) v = 16'($urandom_range(1, 12));
      else if (r < 70) v = 16'hFFFF;
      else v = 16'($urandom_range(1, 65535));
      write_reg(REG_NODE_LIMIT, v);
      write_reg(REG_INEDGE_LIMIT, pick_edge_limit());
      write_reg(REG_OUTEDGE_LIMIT, pick_edge_limit());
      n_settings++;
      len = $urandom_range(40, 160);
      for (int i = 0; i < len && sent < RANDOM_NODES; i++) begin
        w.clear_first = ($urandom_range(0, 99) < 3);
        if ($urandom_range(0, 9) == 0)
          w.start_partition = 4'($urandom_range(0, 15));
        else
          w.start_partition = 4'($urandom_range(0, active_parts() - 1));
        w.in_degree = pick_degree(in_lim_reg);
        w.out_degree = pick_degree(out_lim_reg);
        send_node(w, !(sent >= 500 && sent < 800));
        sent++;
        if ($urandom_range(0, 199) == 0) settle();
      end
    end

    settle();
    repeat (20) @(negedge clk);
    errors += placements_due.size();

    $display("Nodes sent: %0d under %0d register settings.", n_nodes, n_settings);
    $display("Results: %0d placed, %0d with no fit, %0d with a bad start partition.",
             n_placed, n_nofit, n_bad);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("Failures: %0d", errors);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
